>>> design/rhc_pkg.sv
// Shared types and constants of the RGB to HSL converter.
// Used by rhc_front and rgb_to_hls_converter; depends on nothing else.
package rhc_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int SUM_W        = CHANNEL_BITS + 1;
    localparam int NUM_W        = CHANNEL_BITS + 3;
    localparam int SAT_NUM_W    = 2 * CHANNEL_BITS;
    localparam int HUE_NUM_W    = 2 * CHANNEL_BITS + 3;

    localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] hue;
        logic [CHANNEL_BITS-1:0] lightness;
        logic [CHANNEL_BITS-1:0] saturation;
    } hls_t;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    typedef struct packed {
        logic [SAT_NUM_W-1:0]    sat_num;
        logic [SUM_W-1:0]        sat_den;
        logic [HUE_NUM_W-1:0]    hue_num;
        logic [NUM_W-1:0]        hue_den;
        logic [CHANNEL_BITS-1:0] light;
    } div_req_t;

endpackage

>>> design/rhc_front.sv
// Front end of the converter: two register stages that find max, min and sector,
// then build the dividends and divisors of saturation and hue. Depends on rhc_pkg.
module rhc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rhc_pkg::rgb_t     pixel,
    output logic              req_valid,
    output rhc_pkg::div_req_t req
);

    logic [rhc_pkg::CHANNEL_BITS-1:0] mx;
    logic [rhc_pkg::CHANNEL_BITS-1:0] mn;
    rhc_pkg::sector_t                 sector_next;
    logic [rhc_pkg::SUM_W-1:0]        sum_next;
    logic [rhc_pkg::CHANNEL_BITS-1:0] d_next;
    logic [rhc_pkg::SUM_W-1:0]        diff_next;

    logic                             valid_a_reg;
    rhc_pkg::sector_t                 sector_reg;
    logic [rhc_pkg::SUM_W-1:0]        sum_reg;
    logic [rhc_pkg::CHANNEL_BITS-1:0] d_reg;
    logic [rhc_pkg::SUM_W-1:0]        diff_reg;

    logic [rhc_pkg::NUM_W:0]          diff_ext;
    logic [rhc_pkg::NUM_W-1:0]        d6;
    logic [rhc_pkg::NUM_W:0]          base;
    logic [rhc_pkg::NUM_W:0]          n_full;
    logic [rhc_pkg::NUM_W-1:0]        n;
    rhc_pkg::div_req_t                req_next;

    logic                             valid_b_reg;
    rhc_pkg::div_req_t                req_reg;

    always_comb
    begin
        mx = pixel.red;
        mn = pixel.red;
        if (pixel.green > mx)
        begin
            mx = pixel.green;
        end
        if (pixel.blue > mx)
        begin
            mx = pixel.blue;
        end
        if (pixel.green < mn)
        begin
            mn = pixel.green;
        end
        if (pixel.blue < mn)
        begin
            mn = pixel.blue;
        end

        sum_next = rhc_pkg::SUM_W'(mx) + rhc_pkg::SUM_W'(mn);
        d_next   = mx - mn;

        if (pixel.red == mx)
        begin
            sector_next = rhc_pkg::SECTOR_RED;
            diff_next   = rhc_pkg::SUM_W'(pixel.green) - rhc_pkg::SUM_W'(pixel.blue);
        end
        else if (pixel.green == mx)
        begin
            sector_next = rhc_pkg::SECTOR_GREEN;
            diff_next   = rhc_pkg::SUM_W'(pixel.blue) - rhc_pkg::SUM_W'(pixel.red);
        end
        else
        begin
            sector_next = rhc_pkg::SECTOR_BLUE;
            diff_next   = rhc_pkg::SUM_W'(pixel.red) - rhc_pkg::SUM_W'(pixel.green);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= start;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sector_reg <= sector_next;
        sum_reg    <= sum_next;
        d_reg      <= d_next;
        diff_reg   <= diff_next;
        req_reg    <= req_next;
    end

    always_comb
    begin
        diff_ext = {{(rhc_pkg::NUM_W + 1 - rhc_pkg::SUM_W){diff_reg[rhc_pkg::SUM_W-1]}},
                    diff_reg};
        d6 = (rhc_pkg::NUM_W'(d_reg) << 2) + (rhc_pkg::NUM_W'(d_reg) << 1);

        case (sector_reg)
            rhc_pkg::SECTOR_RED:
            begin
                base = diff_reg[rhc_pkg::SUM_W-1] ? {1'b0, d6} : '0;
            end
            rhc_pkg::SECTOR_GREEN:
            begin
                base = (rhc_pkg::NUM_W + 1)'(d_reg) << 1;
            end
            rhc_pkg::SECTOR_BLUE:
            begin
                base = (rhc_pkg::NUM_W + 1)'(d_reg) << 2;
            end
            default:
            begin
                base = '0;
            end
        endcase

        n_full = base + diff_ext;
        n      = n_full[rhc_pkg::NUM_W-1:0];

        req_next.hue_num = (rhc_pkg::HUE_NUM_W'(n) << rhc_pkg::CHANNEL_BITS)
                         - rhc_pkg::HUE_NUM_W'(n);
        req_next.sat_num = (rhc_pkg::SAT_NUM_W'(d_reg) << rhc_pkg::CHANNEL_BITS)
                         - rhc_pkg::SAT_NUM_W'(d_reg);
        req_next.light   = sum_reg[rhc_pkg::SUM_W-1:1];

        if (d_reg == '0)
        begin
            req_next.sat_den = rhc_pkg::SUM_W'(1);
            req_next.hue_den = rhc_pkg::NUM_W'(1);
        end
        else
        begin
            req_next.hue_den = d6;
            if (sum_reg < rhc_pkg::SUM_W'(rhc_pkg::CH_MAX))
            begin
                req_next.sat_den = sum_reg;
            end
            else
            begin
                req_next.sat_den = (rhc_pkg::SUM_W'(rhc_pkg::CH_MAX) << 1) - sum_reg;
            end
        end
    end

    assign req_valid = valid_b_reg;
    assign req       = req_reg;

endmodule

>>> design/rhc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in QUOT_W bits. Depends on no package.
module rhc_div
#(
    parameter int DIVIDEND_W = 16,
    parameter int DIVISOR_W  = 9,
    parameter int QUOT_W     = 8
)
(
    input  logic                  clk,
    input  logic [DIVIDEND_W-1:0] num,
    input  logic [DIVISOR_W-1:0]  den,
    output logic [QUOT_W-1:0]     quot
);

    localparam int CMP_W = (DIVIDEND_W > DIVISOR_W + QUOT_W) ? DIVIDEND_W
                                                             : DIVISOR_W + QUOT_W;

    logic [CMP_W-1:0]     rem_reg  [QUOT_W-1];
    logic [DIVISOR_W-1:0] den_reg  [QUOT_W-1];
    logic [QUOT_W-1:0]    quot_reg [QUOT_W];

    for (genvar s = 0; s < QUOT_W; s++)
    begin : g_stage
        localparam int BIT = QUOT_W - 1 - s;

        logic [CMP_W-1:0]     rem_in;
        logic [DIVISOR_W-1:0] den_in;
        logic [QUOT_W-1:0]    quot_in;
        logic [CMP_W-1:0]     shifted;
        logic [CMP_W-1:0]     rem_next;
        logic [QUOT_W-1:0]    quot_next;

        if (s == 0)
        begin : g_first
            assign rem_in  = CMP_W'(num);
            assign den_in  = den;
            assign quot_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign quot_in = quot_reg[s-1];
        end

        always_comb
        begin
            shifted   = CMP_W'(den_in) << BIT;
            quot_next = quot_in;
            if (rem_in >= shifted)
            begin
                rem_next       = rem_in - shifted;
                quot_next[BIT] = 1'b1;
            end
            else
            begin
                rem_next = rem_in;
            end
        end

        always_ff @(posedge clk)
        begin
            quot_reg[s] <= quot_next;
        end

        if (s < QUOT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quot = quot_reg[QUOT_W-1];

endmodule

>>> design/rgb_to_hls_converter.sv
// RGB to HSL converter: one item per clock, through two front stages, then one
// stage per quotient bit of the saturation and hue dividers. busy is always low
// and done marks each result for one cycle. Reset clears the valid bits only,
// so no result appears until items are started. Depends on rhc_pkg, rhc_front
// and rhc_div.
module rgb_to_hls_converter
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rhc_pkg::rgb_t pixel,
    output logic          done,
    output rhc_pkg::hls_t hls
);

    localparam int DEPTH = rhc_pkg::CHANNEL_BITS;

    logic                             req_valid;
    rhc_pkg::div_req_t                req;
    logic [rhc_pkg::CHANNEL_BITS-1:0] hue_q;
    logic [rhc_pkg::CHANNEL_BITS-1:0] sat_q;

    logic                             vld_reg   [DEPTH];
    logic [rhc_pkg::CHANNEL_BITS-1:0] light_reg [DEPTH];

    assign busy = 1'b0;

    rhc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .pixel     (pixel),
        .req_valid (req_valid),
        .req       (req)
    );

    rhc_div
    #(
        .DIVIDEND_W (rhc_pkg::SAT_NUM_W),
        .DIVISOR_W  (rhc_pkg::SUM_W),
        .QUOT_W     (rhc_pkg::CHANNEL_BITS)
    )
    u_sat_div
    (
        .clk  (clk),
        .num  (req.sat_num),
        .den  (req.sat_den),
        .quot (sat_q)
    );

    rhc_div
    #(
        .DIVIDEND_W (rhc_pkg::HUE_NUM_W),
        .DIVISOR_W  (rhc_pkg::NUM_W),
        .QUOT_W     (rhc_pkg::CHANNEL_BITS)
    )
    u_hue_div
    (
        .clk  (clk),
        .num  (req.hue_num),
        .den  (req.hue_den),
        .quot (hue_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= req_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        light_reg[0] <= req.light;
        for (int i = 1; i < DEPTH; i++)
        begin
            light_reg[i] <= light_reg[i-1];
        end
    end

    assign done           = vld_reg[DEPTH-1];
    assign hls.hue        = hue_q;
    assign hls.lightness  = light_reg[DEPTH-1];
    assign hls.saturation = sat_q;

endmodule
